// ----- design/ftg_pkg.sv -----
// shared types, register codes and rotation-angle table for the twiddle generator
package ftg_pkg;

   localparam int SIZE_BITS  = 17;
   localparam int PHASE_BITS = 32;
   localparam int CW         = 34;   // cordic datapath width, q2.30 plus headroom

   localparam logic [0:0] REG_TRANSFORM_SIZE    = 1'b0;
   localparam logic [0:0] REG_INVERSE_DIRECTION = 1'b1;

   localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   typedef struct packed {
      logic [SIZE_BITS-1:0]  rem;
      logic [PHASE_BITS-1:0] quot;
      logic                  oor;
   } div_data_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic [1:0]           q;
      logic                 oor;
   } cordic_data_type;

   // rotation angles in units of 2^-32 turn
   function automatic logic [31:0] atan_turns(input logic [4:0] idx);
      logic [31:0] a;
      case (idx)
         5'd0:  a = 32'd536870912;
         5'd1:  a = 32'd316933406;
         5'd2:  a = 32'd167458907;
         5'd3:  a = 32'd85004756;
         5'd4:  a = 32'd42667331;
         5'd5:  a = 32'd21354465;
         5'd6:  a = 32'd10679838;
         5'd7:  a = 32'd5340245;
         5'd8:  a = 32'd2670163;
         5'd9:  a = 32'd1335087;
         5'd10: a = 32'd667544;
         5'd11: a = 32'd333772;
         5'd12: a = 32'd166886;
         5'd13: a = 32'd83443;
         5'd14: a = 32'd41722;
         5'd15: a = 32'd20861;
         5'd16: a = 32'd10430;
         5'd17: a = 32'd5215;
         5'd18: a = 32'd2608;
         5'd19: a = 32'd1304;
         5'd20: a = 32'd652;
         5'd21: a = 32'd326;
         5'd22: a = 32'd163;
         5'd23: a = 32'd81;
         5'd24: a = 32'd41;
         5'd25: a = 32'd20;
         5'd26: a = 32'd10;
         5'd27: a = 32'd5;
         5'd28: a = 32'd3;
         5'd29: a = 32'd1;
         5'd30: a = 32'd1;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

endpackage

// ----- design/ftg_div_cell.sv -----
// one restoring-division cell: one quotient bit of the phase per cell
module ftg_div_cell
   import ftg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [SIZE_BITS-1:0] size,
   input  logic                 valid_i,
   input  div_data_type         data_i,
   output logic                 valid_o,
   output div_data_type         data_o
);

   logic                 valid_ff;
   div_data_type         data_ff;
   div_data_type         data_in;
   logic [SIZE_BITS:0]   twice;
   logic                 fits;

   always_comb begin
      twice        = {data_i.rem, 1'b0};
      fits         = twice >= {1'b0, size};
      data_in.oor  = data_i.oor;
      data_in.quot = {data_i.quot[PHASE_BITS-2:0], fits};
      data_in.rem  = fits ? SIZE_BITS'(twice - {1'b0, size}) : SIZE_BITS'(twice);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule

// ----- design/ftg_cordic_cell.sv -----
// one cordic rotation cell with a fixed shift and angle
module ftg_cordic_cell
   import ftg_pkg::*;
#(
   parameter int STAGE = 0
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            valid_i,
   input  cordic_data_type data_i,
   output logic            valid_o,
   output cordic_data_type data_o
);

   localparam logic signed [CW-1:0] ANGLE = CW'(atan_turns(5'(STAGE)));

   logic            valid_ff;
   cordic_data_type data_ff;
   cordic_data_type data_in;
   logic signed [CW-1:0] dx;
   logic signed [CW-1:0] dy;

   always_comb begin
      dx          = data_i.y >>> STAGE;
      dy          = data_i.x >>> STAGE;
      data_in.q   = data_i.q;
      data_in.oor = data_i.oor;
      if (!data_i.z[CW-1]) begin
         data_in.x = data_i.x - dx;
         data_in.y = data_i.y + dy;
         data_in.z = data_i.z - ANGLE;
      end else begin
         data_in.x = data_i.x + dx;
         data_in.y = data_i.y - dy;
         data_in.z = data_i.z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule

// ----- design/fft_twiddle_generator_unit.sv -----
// top level of the fft twiddle factor generator: divider chain, cordic chain, output stage
//
//   channel | ports                          | direction | transfer when
//   --------+--------------------------------+-----------+--------------------------
//   req     | req_valid/ready, twiddle_index | in        | req_valid && req_ready
//   rsp     | rsp_valid/ready, cos/sin, oor  | out       | rsp_valid && rsp_ready
//   csr     | write_enable, index, data      | in        | csr_write_enable
//
// one index per cycle sustained while results are taken; each index passes in order
// through the entry stage, 32 division cells, the quadrant stage, the cordic cells
// and the output stage. the whole chain moves as one: it advances whenever the
// output register is empty or being taken, so a stalled result holds every stage.
// reset clears all valid bits and loads size 1024, forward direction.
module fft_twiddle_generator_unit
   import ftg_pkg::*;
#(
   parameter int INDEX_WIDTH   = 16,
   parameter int DATA_WIDTH    = 16,
   parameter int CORDIC_STAGES = 16
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [INDEX_WIDTH-1:0]       req_twiddle_index,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_cos_part,
   output logic signed [DATA_WIDTH-1:0] rsp_sin_part,
   output logic                         rsp_index_out_of_range,
   input  logic                         csr_write_enable,
   input  logic [0:0]                   csr_index,
   input  logic [SIZE_BITS-1:0]         csr_write_data
);

   localparam int NDIV   = PHASE_BITS;
   localparam int SH     = 31 - DATA_WIDTH;
   localparam int RND_SH = (SH > 0) ? SH : 0;
   localparam logic signed [CW-1:0] RND_ADD =
      (SH > 0) ? (CW'(1) <<< (RND_SH > 0 ? RND_SH - 1 : 0)) : '0;
   localparam logic signed [CW-1:0] OUT_HI = CW'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
   localparam logic signed [CW-1:0] OUT_LO = -CW'(64'sd1 <<< (DATA_WIDTH - 1));

   // configuration
   logic [SIZE_BITS-1:0] size_ff;
   logic                 inverse_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= SIZE_BITS'(1024);
         inverse_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_TRANSFORM_SIZE:    size_ff    <= csr_write_data;
            REG_INVERSE_DIRECTION: inverse_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // whole chain advances when the output register is free or draining
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // entry stage: range check and division seed
   logic [31:0]  k_ext;
   logic         entry_valid_ff;
   div_data_type entry_ff;
   div_data_type entry_in;

   always_comb begin
      k_ext         = 32'(req_twiddle_index);
      entry_in.oor  = (size_ff == '0) || (k_ext >= 32'(size_ff));
      entry_in.rem  = k_ext[SIZE_BITS-1:0];
      entry_in.quot = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= req_valid;
      end
      if (advance) begin
         entry_ff <= entry_in;
      end
   end

   // division chain: phase = floor(k * 2^32 / n), one bit per cell
   logic         div_vld [NDIV+1];
   div_data_type div_bus [NDIV+1];
   assign div_vld[0] = entry_valid_ff;
   assign div_bus[0] = entry_ff;

   for (genvar i = 0; i < NDIV; i++) begin : g_div
      ftg_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .size    (size_ff),
         .valid_i (div_vld[i]),
         .data_i  (div_bus[i]),
         .valid_o (div_vld[i+1]),
         .data_o  (div_bus[i+1])
      );
   end

   // quadrant stage: direction, nearest quadrant, residual angle
   logic [31:0]     phase;
   logic [31:0]     phase_q;
   logic            quad_valid_ff;
   cordic_data_type quad_ff;
   cordic_data_type quad_in;

   always_comb begin
      phase       = inverse_ff ? div_bus[NDIV].quot : (32'd0 - div_bus[NDIV].quot);
      phase_q     = phase + 32'h2000_0000;
      quad_in.q   = phase_q[31:30];
      quad_in.z   = CW'(signed'(phase[29:0]));
      quad_in.x   = CORDIC_GAIN_Q30;
      quad_in.y   = '0;
      quad_in.oor = div_bus[NDIV].oor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_valid_ff <= 1'b0;
      end else if (advance) begin
         quad_valid_ff <= div_vld[NDIV];
      end
      if (advance) begin
         quad_ff <= quad_in;
      end
   end

   // cordic chain
   logic            cor_vld [CORDIC_STAGES+1];
   cordic_data_type cor_bus [CORDIC_STAGES+1];
   assign cor_vld[0] = quad_valid_ff;
   assign cor_bus[0] = quad_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      ftg_cordic_cell #(.STAGE(i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .valid_i (cor_vld[i]),
         .data_i  (cor_bus[i]),
         .valid_o (cor_vld[i+1]),
         .data_o  (cor_bus[i+1])
      );
   end

   // output stage: quadrant unfold, round half up, saturate
   function automatic logic [DATA_WIDTH-1:0] to_output(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] r;
      r = (v + RND_ADD) >>> RND_SH;
      if (r > OUT_HI) r = OUT_HI;
      if (r < OUT_LO) r = OUT_LO;
      return r[DATA_WIDTH-1:0];
   endfunction

   cordic_data_type      last;
   logic signed [CW-1:0] c_raw;
   logic signed [CW-1:0] s_raw;
   logic                 rsp_valid_ff;
   logic signed [DATA_WIDTH-1:0] cos_ff;
   logic signed [DATA_WIDTH-1:0] sin_ff;
   logic                 oor_ff;

   always_comb begin
      last = cor_bus[CORDIC_STAGES];
      case (last.q)
         2'd0: begin c_raw = last.x;  s_raw = last.y;  end
         2'd1: begin c_raw = -last.y; s_raw = last.x;  end
         2'd2: begin c_raw = -last.x; s_raw = -last.y; end
         default: begin c_raw = last.y; s_raw = -last.x; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= cor_vld[CORDIC_STAGES];
      end
      if (advance) begin
         oor_ff <= last.oor;
         cos_ff <= last.oor ? '0 : to_output(c_raw);
         sin_ff <= last.oor ? '0 : to_output(s_raw);
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_cos_part           = cos_ff;
   assign rsp_sin_part           = sin_ff;
   assign rsp_index_out_of_range = oor_ff;

`ifndef SYNTHESIS
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_out_of_range |-> rsp_cos_part == '0 && rsp_sin_part == '0)
      else $error("out-of-range result carries nonzero parts");
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with output free");
   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
